// ===== design/rebc_pkg.sv =====
package rebc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned TdataWidth   = 40;

  localparam logic [CfgIdxWidth-1:0] REG_BOUND_LOW       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BOUND_HIGH      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_WRAP_MODE       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BOUNDS_ENABLE   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_STEP_COOLDOWN   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_BUTTON_COOLDOWN = 3'd5;

  localparam logic [15:0] STEP_COOLDOWN_RESET   = 16'd2;
  localparam logic [15:0] BUTTON_COOLDOWN_RESET = 16'd50;

  typedef struct packed {
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
    logic               wrap_mode;
    logic               bounds_enable;
    logic [15:0]        step_cooldown_ms;
    logic [15:0]        button_cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        clock_level;
    logic        data_level;
    logic        button_level;
  } poll_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               moved_cw;
    logic               moved_ccw;
    logic               button_pressed;
  } result_t;

endpackage

// ===== design/rotary_encoder_bounded_counter_unit.sv =====
// Rotary encoder position counter with button debounce.
// Each beat on the s_ channel is one poll of the encoder pins with a
// millisecond timestamp; each poll yields exactly one beat on the m_
// channel carrying the position after the poll and the step and press flags.
// A poll is held in an input register, evaluated in a single pass of
// compare and increment logic that also updates the encoder state, and the
// result is captured in an output register. Throughput is one poll per cycle
// while the receiver keeps m_tready high; the state update and the output
// register load happen in the same cycle, so consecutive polls need no gap.
// When the receiver holds m_tready low, the result register keeps its beat,
// the input register keeps the next poll, and s_tready drops once both are
// full; nothing is lost or repeated.
// Synchronous reset restores the register defaults (step cooldown 2 ms,
// button cooldown 50 ms, bounds off) and the encoder state (clock line high,
// button released, position zero) and empties both registers.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at the
// next clock edge and are to be made only while no poll is in flight.
module rotary_encoder_bounded_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // now_ms[31:0], clock_level[32], data_level[33], button_level[34], zero fill
  input  logic [rebc_pkg::TdataWidth-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // position[31:0], moved_cw[32], moved_ccw[33], button_pressed[34], zero fill
  output logic [rebc_pkg::TdataWidth-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [rebc_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [rebc_pkg::CfgDataWidth-1:0]    cfg_data
);

  rebc_pkg::cfg_t    cfg;
  rebc_pkg::poll_t   poll;
  rebc_pkg::result_t result;
  rebc_pkg::result_t out_beat;
  logic              in_valid;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      poll.now_ms       <= s_tdata[31:0];
      poll.clock_level  <= s_tdata[32];
      poll.data_level   <= s_tdata[33];
      poll.button_level <= s_tdata[34];
    end
    if (advance) begin
      out_beat <= result;
    end
  end

  assign m_tdata = {5'd0, out_beat.button_pressed, out_beat.moved_ccw, out_beat.moved_cw,
                    out_beat.position};

  rebc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rebc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .poll    (poll),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// ===== design/rebc_cfg.sv =====
module rebc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rebc_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [rebc_pkg::CfgDataWidth-1:0]    cfg_data,
  output rebc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bound_low          <= '0;
      cfg.bound_high         <= '0;
      cfg.wrap_mode          <= 1'b0;
      cfg.bounds_enable      <= 1'b0;
      cfg.step_cooldown_ms   <= rebc_pkg::STEP_COOLDOWN_RESET;
      cfg.button_cooldown_ms <= rebc_pkg::BUTTON_COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rebc_pkg::REG_BOUND_LOW:       cfg.bound_low          <= cfg_data;
        rebc_pkg::REG_BOUND_HIGH:      cfg.bound_high         <= cfg_data;
        rebc_pkg::REG_WRAP_MODE:       cfg.wrap_mode          <= cfg_data[0];
        rebc_pkg::REG_BOUNDS_ENABLE:   cfg.bounds_enable      <= cfg_data[0];
        rebc_pkg::REG_STEP_COOLDOWN:   cfg.step_cooldown_ms   <= cfg_data[15:0];
        rebc_pkg::REG_BUTTON_COOLDOWN: cfg.button_cooldown_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rebc_core.sv =====
module rebc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rebc_pkg::poll_t   poll,
  input  rebc_pkg::cfg_t    cfg,
  output rebc_pkg::result_t result
);

  logic               last_clock, last_clock_next;
  logic               button_state, button_state_next;
  logic [31:0]        button_sample_time, button_sample_time_next;
  logic [31:0]        step_time, step_time_next;
  logic signed [31:0] count, count_next;

  logic [31:0] button_elapsed;
  logic [31:0] step_elapsed;
  logic        button_due;
  logic        step_due;
  logic        take_step;

  always_comb begin
    button_elapsed = poll.now_ms - button_sample_time;
    step_elapsed   = poll.now_ms - step_time;
    button_due     = button_elapsed > {16'd0, cfg.button_cooldown_ms};
    step_due       = step_elapsed >= {16'd0, cfg.step_cooldown_ms};

    button_state_next       = button_state;
    button_sample_time_next = button_sample_time;
    last_clock_next         = last_clock;
    step_time_next          = step_time;
    count_next              = count;
    result.moved_cw         = 1'b0;
    result.moved_ccw        = 1'b0;
    result.button_pressed   = 1'b0;

    if (button_due) begin
      button_sample_time_next = poll.now_ms;
      button_state_next       = poll.button_level;
      result.button_pressed   = poll.button_level && !button_state;
    end

    take_step = step_due && (poll.clock_level != last_clock);
    if (take_step) begin
      last_clock_next = poll.clock_level;
      if (!poll.clock_level) begin
        step_time_next = poll.now_ms;
        if (poll.data_level) begin
          result.moved_cw = 1'b1;
          // count + 1 > high is count >= high, free of overflow.
          if (cfg.bounds_enable && (count >= cfg.bound_high)) begin
            count_next = cfg.wrap_mode ? cfg.bound_low : cfg.bound_high;
          end else begin
            count_next = count + 32'sd1;
          end
        end else begin
          result.moved_ccw = 1'b1;
          if (cfg.bounds_enable && (count <= cfg.bound_low)) begin
            count_next = cfg.wrap_mode ? cfg.bound_high : cfg.bound_low;
          end else begin
            count_next = count - 32'sd1;
          end
        end
      end
    end

    result.position = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock         <= 1'b1;
      button_state       <= 1'b0;
      button_sample_time <= '0;
      step_time          <= '0;
      count              <= '0;
    end else if (advance) begin
      last_clock         <= last_clock_next;
      button_state       <= button_state_next;
      button_sample_time <= button_sample_time_next;
      step_time          <= step_time_next;
      count              <= count_next;
    end
  end

endmodule

// ===== bench/tb_rotary_encoder_bounded_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_rotary_encoder_bounded_counter_unit;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [rebc_pkg::TdataWidth-1:0]   s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [rebc_pkg::TdataWidth-1:0]   m_tdata;
  logic                              cfg_we = 1'b0;
  logic [rebc_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [rebc_pkg::CfgDataWidth-1:0] cfg_data = '0;

  rotary_encoder_bounded_counter_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rebc_pkg::cfg_t     settings;
  logic               enc_clock_q;
  logic               button_q;
  logic [31:0]        button_time_q;
  logic [31:0]        step_time_q;
  logic signed [31:0] position_q;

  rebc_pkg::result_t expected_positions[$];
  int      errors;
  int      polls_sent;
  int      beats_checked;
  int      cw_seen;
  int      ccw_seen;
  int      presses_seen;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic [31:0] poll_ms;

  function automatic rebc_pkg::result_t track_encoder(rebc_pkg::poll_t p);
    rebc_pkg::result_t r;
    logic [31:0] elapsed;
    longint      cur;
    longint      lo;
    longint      hi;
    r = '0;
    elapsed = p.now_ms - button_time_q;
    if (elapsed > {16'd0, settings.button_cooldown_ms}) begin
      button_time_q = p.now_ms;
      if (p.button_level != button_q) begin
        r.button_pressed = p.button_level;
        button_q = p.button_level;
      end
    end
    elapsed = p.now_ms - step_time_q;
    if (elapsed >= {16'd0, settings.step_cooldown_ms} && p.clock_level != enc_clock_q) begin
      enc_clock_q = p.clock_level;
      if (!p.clock_level) begin
        step_time_q = p.now_ms;
        cur = position_q;
        lo = settings.bound_low;
        hi = settings.bound_high;
        if (p.data_level) begin
          r.moved_cw = 1'b1;
          if (settings.bounds_enable && cur + 1 > hi) begin
            position_q = settings.wrap_mode ? settings.bound_low : settings.bound_high;
          end else begin
            position_q = position_q + 32'sd1;
          end
        end else begin
          r.moved_ccw = 1'b1;
          if (settings.bounds_enable && cur - 1 < lo) begin
            position_q = settings.wrap_mode ? settings.bound_high : settings.bound_low;
          end else begin
            position_q = position_q - 32'sd1;
          end
        end
      end
    end
    r.position = position_q;
    return r;
  endfunction

  function automatic rebc_pkg::poll_t make_poll(logic [31:0] t, logic c, logic d, logic b);
    rebc_pkg::poll_t p;
    p.now_ms = t;
    p.clock_level = c;
    p.data_level = d;
    p.button_level = b;
    return p;
  endfunction

  task automatic send_poll(rebc_pkg::poll_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, p.button_level, p.data_level, p.clock_level, p.now_ms};
    do @(posedge clk); while (!s_tready);
    expected_positions.push_back(track_encoder(p));
    polls_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [rebc_pkg::CfgIdxWidth-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      rebc_pkg::REG_BOUND_LOW:       settings.bound_low = value;
      rebc_pkg::REG_BOUND_HIGH:      settings.bound_high = value;
      rebc_pkg::REG_WRAP_MODE:       settings.wrap_mode = value[0];
      rebc_pkg::REG_BOUNDS_ENABLE:   settings.bounds_enable = value[0];
      rebc_pkg::REG_STEP_COOLDOWN:   settings.step_cooldown_ms = value[15:0];
      rebc_pkg::REG_BUTTON_COOLDOWN: settings.button_cooldown_ms = value[15:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic apply_settings(logic signed [31:0] lo, logic signed [31:0] hi, logic wrap,
                                logic en, logic [15:0] step_cd, logic [15:0] btn_cd);
    logic [31:0] junk;
    drain_results();
    junk = $urandom;
    write_reg(rebc_pkg::REG_BOUND_LOW, lo);
    write_reg(rebc_pkg::REG_BOUND_HIGH, hi);
    write_reg(rebc_pkg::REG_WRAP_MODE, {junk[31:1], wrap});
    write_reg(rebc_pkg::REG_BOUNDS_ENABLE, {junk[30:0], en});
    write_reg(rebc_pkg::REG_STEP_COOLDOWN, {junk[15:0], step_cd});
    write_reg(rebc_pkg::REG_BUTTON_COOLDOWN, {junk[23:8], btn_cd});
    cfg_we <= 1'b0;
  endtask

  task automatic poll_at(logic [31:0] delta, logic c, logic d, logic b);
    poll_ms = poll_ms + delta;
    send_poll(make_poll(poll_ms, c, d, b));
  endtask

  task automatic test_reset_defaults();
    poll_ms = 32'd0;
    poll_at(0, 1'b1, 1'b0, 1'b0);
    poll_at(1, 1'b0, 1'b1, 1'b1);
    poll_at(1, 1'b0, 1'b1, 1'b1);
    poll_at(1, 1'b1, 1'b0, 1'b1);
    poll_at(1, 1'b1, 1'b0, 1'b1);
    poll_at(1, 1'b0, 1'b0, 1'b1);
    poll_at(46, 1'b0, 1'b0, 1'b1);
    poll_at(50, 1'b0, 1'b0, 1'b0);
    poll_at(1, 1'b0, 1'b0, 1'b0);
    // The timestamp wraps through zero here.
    send_poll(make_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    send_poll(make_poll(32'h0000_0000, 1'b0, 1'b1, 1'b0));
    poll_ms = 32'd0;
  endtask

  task automatic test_count_extremes();
    apply_settings(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 1'b1, 1'b1, 16'd0, 16'd0);
    poll_at(3, 1'b1, 1'b1, 1'b0);
    poll_at(3, 1'b0, 1'b0, 1'b0);
    apply_settings(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 1'b1, 1'b0, 16'd0, 16'd0);
    poll_at(3, 1'b1, 1'b0, 1'b0);
    poll_at(3, 1'b0, 1'b1, 1'b0);
    apply_settings(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b1, 16'd0, 16'd0);
    poll_at(3, 1'b1, 1'b1, 1'b0);
    poll_at(3, 1'b0, 1'b1, 1'b0);
    poll_at(3, 1'b1, 1'b0, 1'b0);
    poll_at(3, 1'b0, 1'b0, 1'b0);
    apply_settings(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0, 16'd0, 16'd0);
    poll_at(3, 1'b1, 1'b0, 1'b0);
    poll_at(3, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_inverted_bounds_long_cooldowns();
    apply_settings(32'sd10, -32'sd10, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    poll_at(32'd70000, 1'b1, 1'b0, 1'b1);
    poll_at(32'd65535, 1'b0, 1'b1, 1'b1);
    poll_at(32'd65534, 1'b1, 1'b0, 1'b0);
    poll_at(32'd1, 1'b1, 1'b0, 1'b0);
    poll_at(32'd65535, 1'b0, 1'b0, 1'b0);
  endtask

  // Mostly a regular detent rhythm with random timing; the rest is noise.
  task automatic run_polls(int n);
    logic        enc_clk;
    logic        enc_dat;
    logic        turn_cw;
    logic        btn;
    logic [31:0] delta;
    enc_clk = enc_clock_q;
    turn_cw = 1'($urandom_range(1));
    btn = button_q;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      if ($urandom_range(99) < 85) begin
        enc_clk = ~enc_clk;
        if ($urandom_range(4) == 0) turn_cw = ~turn_cw;
        enc_dat = enc_clk ? 1'($urandom_range(1)) : turn_cw;
        delta = $urandom_range(settings.step_cooldown_ms + 2);
      end else begin
        enc_clk = 1'($urandom_range(1));
        enc_dat = 1'($urandom_range(1));
        delta = ($urandom_range(3) == 0) ? $urandom
                                         : $urandom_range(settings.button_cooldown_ms + 2);
      end
      if ($urandom_range(7) == 0) btn = ~btn;
      poll_at(delta, enc_clk, enc_dat, btn);
    end
  endtask

  task automatic test_unbounded_free_running();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_settings(32'sd0, 32'sd0, 1'b0, 1'b0, 16'd0, 16'd0);
    run_polls(130);
  endtask

  task automatic test_clamped_bounds();
    send_idle_pct = 79;
    recv_stall_pct = 0;
    apply_settings(-32'sd5, 32'sd5, 1'b0, 1'b1, 16'd3, 16'd7);
    run_polls(130);
  endtask

  task automatic test_wrapped_bounds();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    apply_settings(-32'sd3, 32'sd4, 1'b1, 1'b1, 16'd1, 16'd2);
    run_polls(130);
  endtask

  task automatic test_random_settings();
    int lo;
    int hi;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    for (int k = 0; k < 4; k++) begin
      lo = int'($urandom_range(30)) - 15;
      hi = lo + int'($urandom_range(20)) - 3;
      apply_settings(lo, hi, 1'($urandom_range(1)), $urandom_range(3) != 0,
                     16'($urandom_range(4)), 16'($urandom_range(6)));
      run_polls(33);
    end
  endtask

  always @(posedge clk) begin
    rebc_pkg::result_t want;
    rebc_pkg::result_t got;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.position = m_tdata[31:0];
      got.moved_cw = m_tdata[32];
      got.moved_ccw = m_tdata[33];
      got.button_pressed = m_tdata[34];
      if (expected_positions.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual position %0d",
                 $time, got.position);
      end else begin
        want = expected_positions.pop_front();
        beats_checked++;
        cw_seen += want.moved_cw;
        ccw_seen += want.moved_ccw;
        presses_seen += want.button_pressed;
        if (got.position !== want.position) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   got.position);
        end
        if (got.moved_cw !== want.moved_cw) begin
          errors++;
          $display("%0t: moved_cw expected %b actual %b", $time, want.moved_cw, got.moved_cw);
        end
        if (got.moved_ccw !== want.moved_ccw) begin
          errors++;
          $display("%0t: moved_ccw expected %b actual %b", $time, want.moved_ccw,
                   got.moved_ccw);
        end
        if (got.button_pressed !== want.button_pressed) begin
          errors++;
          $display("%0t: button_pressed expected %b actual %b", $time, want.button_pressed,
                   got.button_pressed);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_rotary_encoder_bounded_counter_unit failed");
    $finish;
  end

  initial begin
    errors = 0;
    polls_sent = 0;
    beats_checked = 0;
    cw_seen = 0;
    ccw_seen = 0;
    presses_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    poll_ms = 32'd0;
    settings = '0;
    settings.step_cooldown_ms = rebc_pkg::STEP_COOLDOWN_RESET;
    settings.button_cooldown_ms = rebc_pkg::BUTTON_COOLDOWN_RESET;
    enc_clock_q = 1'b1;
    button_q = 1'b0;
    button_time_q = 32'd0;
    step_time_q = 32'd0;
    position_q = 32'sd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_count_extremes();
    test_inverted_bounds_long_cooldowns();
    test_unbounded_free_running();
    test_clamped_bounds();
    test_wrapped_bounds();
    test_random_settings();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d polls and checked %0d result beats under four stall patterns.",
             polls_sent, beats_checked);
    $display("Checked beats held %0d clockwise steps, %0d counterclockwise, %0d presses.",
             cw_seen, ccw_seen, presses_seen);
    if (errors == 0) begin
      $display("tb_rotary_encoder_bounded_counter_unit passed");
    end else begin
      $display("tb_rotary_encoder_bounded_counter_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rebc_pkg.sv
design/rebc_cfg.sv
design/rebc_core.sv
design/rotary_encoder_bounded_counter_unit.sv
bench/tb_rotary_encoder_bounded_counter_unit.sv
